[rtl/segment_stream_normalizer_unit_defines.svh]
// Assertion macros shared by the segment stream normalizer modules.
`ifndef SEGMENT_STREAM_NORMALIZER_UNIT_DEFINES_SVH
`define SEGMENT_STREAM_NORMALIZER_UNIT_DEFINES_SVH

// The condition must never hold while out of reset.
`define SSN_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("ssn: forbidden condition seen");

// The antecedent must always be followed by the consequent in the same cycle.
`define SSN_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ssn: implication violated");

`endif

[rtl/ssn_pkg.sv]
package ssn_pkg;

  typedef enum logic [3:0] {
    PH_HDR_FIRST = 4'b0001,
    PH_HDR_BODY  = 4'b0010,
    PH_DATA      = 4'b0100,
    PH_DISCARD   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_HDR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] data;
    logic        fin;
    logic        run;
    logic [15:0] first_start;
  } entry_t;

  localparam logic [7:0]  MARKER_BYTE  = 8'hFF;
  localparam logic [15:0] MARKER_WORD  = 16'hFFFF;
  localparam logic [15:0] RUN_VEC_LO   = 16'h02E0;
  localparam logic [15:0] RUN_VEC_HI   = 16'h02E1;
  localparam logic [15:0] INIT_VEC_LO  = 16'h02E2;
  localparam logic [15:0] INIT_VEC_HI  = 16'h02E3;
  localparam logic [7:0]  RUN_ADDR_LO  = 8'hE0;
  localparam logic [7:0]  RUN_STOP_LO  = 8'hE1;
  localparam logic [7:0]  RUN_ADDR_HI  = 8'h02;
  localparam logic [7:0]  TRAILER_FE   = 8'hFE;

  localparam logic [2:0]  HDR_MARKER_CNT = 3'd2;
  localparam logic [2:0]  HDR_FULL_CNT   = 3'd4;

  localparam logic [3:0] POS_HDR0    = 4'd0;
  localparam logic [3:0] POS_HDR3    = 4'd3;
  localparam logic [3:0] POS_RUN_E0  = 4'd4;
  localparam logic [3:0] POS_RUN_02A = 4'd5;
  localparam logic [3:0] POS_RUN_E1  = 4'd6;
  localparam logic [3:0] POS_RUN_02B = 4'd7;
  localparam logic [3:0] POS_FS_LO   = 4'd8;
  localparam logic [3:0] POS_FS_HI   = 4'd9;
  localparam logic [3:0] POS_TRL_FF0 = 4'd10;
  localparam logic [3:0] POS_TRL_FF1 = 4'd11;
  localparam logic [3:0] POS_TRL_FE  = 4'd12;
  localparam logic [3:0] POS_TRL_FF2 = 4'd13;

  function automatic logic [7:0] tail_byte(logic [3:0] pos, logic [15:0] fs);
    logic [7:0] b;
    b = MARKER_BYTE;
    unique case (pos)
      POS_RUN_E0:  b = RUN_ADDR_LO;
      POS_RUN_02A: b = RUN_ADDR_HI;
      POS_RUN_E1:  b = RUN_STOP_LO;
      POS_RUN_02B: b = RUN_ADDR_HI;
      POS_FS_LO:   b = fs[7:0];
      POS_FS_HI:   b = fs[15:8];
      POS_TRL_FE:  b = TRAILER_FE;
      POS_TRL_FF0, POS_TRL_FF1, POS_TRL_FF2: b = MARKER_BYTE;
      default:     b = MARKER_BYTE;
    endcase
    return b;
  endfunction

endpackage

[rtl/ssn_front.sv]
module ssn_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            push_o,
  output ssn_pkg::entry_t entry_o
);
  import ssn_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] hold_q, hold_d;
  logic [2:0]  count_q, count_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] fs_q, fs_d;
  logic        seen_q, seen_d;
  logic        vec_q, vec_d;

  logic [31:0] hold_new;
  logic [2:0]  cnt_new;
  logic [15:0] start_addr;
  logic [15:0] stop_addr;
  kind_e       kind;

  always_comb begin
    hold_new = hold_q;
    hold_new[{count_q[1:0], 3'b000} +: 8] = in_byte_i;
    cnt_new    = count_q + 3'd1;
    start_addr = hold_new[15:0];
    stop_addr  = hold_new[31:16];

    phase_d = phase_q;
    hold_d  = hold_q;
    count_d = count_q;
    rem_d   = rem_q;
    fs_d    = fs_q;
    seen_d  = seen_q;
    vec_d   = vec_q;
    kind    = KIND_NONE;

    if (accept_i) begin
      unique case (phase_q)
        PH_HDR_FIRST, PH_HDR_BODY: begin
          hold_d  = hold_new;
          count_d = cnt_new;
          if (phase_q == PH_HDR_FIRST && cnt_new == HDR_MARKER_CNT) begin
            phase_d = PH_HDR_BODY;
            if (hold_new[15:0] == MARKER_WORD) begin
              count_d = '0;
              hold_d  = '0;
            end
          end else if (cnt_new == HDR_FULL_CNT) begin
            count_d = '0;
            if (!seen_q) begin
              fs_d   = start_addr;
              seen_d = 1'b1;
            end
            if (start_addr > stop_addr) begin
              phase_d = PH_DISCARD;
            end else begin
              if ((start_addr <= RUN_VEC_LO && stop_addr >= RUN_VEC_HI) ||
                  (start_addr <= INIT_VEC_LO && stop_addr >= INIT_VEC_HI)) begin
                vec_d = 1'b1;
              end
              kind    = KIND_HDR;
              rem_d   = {1'b0, stop_addr} - {1'b0, start_addr} + 17'd1;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          kind  = KIND_BYTE;
          rem_d = rem_q - 17'd1;
          if (rem_d == '0) begin
            phase_d = PH_HDR_FIRST;
            count_d = '0;
          end
        end
        PH_DISCARD: begin
        end
        default: begin
          phase_d = PH_HDR_FIRST;
          count_d = '0;
        end
      endcase
    end

    entry_o.kind        = kind;
    entry_o.data        = (kind == KIND_HDR) ? hold_new : {24'd0, in_byte_i};
    entry_o.fin         = in_last_i;
    entry_o.run         = !vec_d;
    entry_o.first_start = fs_d;
    push_o = accept_i && (kind != KIND_NONE || in_last_i);

    if (accept_i && in_last_i) begin
      phase_d = PH_HDR_FIRST;
      hold_d  = '0;
      count_d = '0;
      rem_d   = '0;
      fs_d    = '0;
      seen_d  = 1'b0;
      vec_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_FIRST;
      hold_q  <= '0;
      count_q <= '0;
      rem_q   <= '0;
      fs_q    <= '0;
      seen_q  <= 1'b0;
      vec_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      fs_q    <= fs_d;
      seen_q  <= seen_d;
      vec_q   <= vec_d;
    end
  end

endmodule

[rtl/ssn_fifo.sv]
`include "segment_stream_normalizer_unit_defines.svh"

module ssn_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ssn_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output ssn_pkg::entry_t head_o,
  output logic            valid_o
);
  import ssn_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SSN_ASSERT_NEVER(a_fifo_no_overflow, clk_i, rst_ni, push_i && full_o)
  `SSN_ASSERT_NEVER(a_fifo_no_underflow, clk_i, rst_ni, pop_i && !valid_o)
  `SSN_ASSERT_NEVER(a_fifo_count_bound, clk_i, rst_ni, count_q > FullCnt)

endmodule

[rtl/ssn_back.sv]
`include "segment_stream_normalizer_unit_defines.svh"

module ssn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssn_pkg::entry_t head_i,
  input  logic            head_valid_i,
  output logic            head_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import ssn_pkg::*;

  logic       busy_q, busy_d;
  logic [3:0] pos_q, pos_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [3:0] start_pos;
  logic [3:0] cur_pos;
  logic [3:0] next_pos;
  logic       entry_done;
  logic       step;
  logic [7:0] cur_byte;

  always_comb begin
    if (head_i.kind != KIND_NONE) begin
      start_pos = POS_HDR0;
    end else begin
      start_pos = head_i.run ? POS_RUN_E0 : POS_TRL_FF0;
    end
    cur_pos = busy_q ? pos_q : start_pos;

    next_pos   = cur_pos + 4'd1;
    entry_done = 1'b0;
    if (cur_pos < POS_RUN_E0) begin
      if (head_i.kind == KIND_HDR) begin
        cur_byte = head_i.data[{cur_pos[1:0], 3'b000} +: 8];
      end else begin
        cur_byte = head_i.data[7:0];
      end
      if (head_i.kind == KIND_HDR && cur_pos != POS_HDR3) begin
        next_pos = cur_pos + 4'd1;
      end else if (head_i.fin) begin
        next_pos = head_i.run ? POS_RUN_E0 : POS_TRL_FF0;
      end else begin
        entry_done = 1'b1;
      end
    end else begin
      cur_byte   = tail_byte(cur_pos, head_i.first_start);
      entry_done = (cur_pos == POS_TRL_FF2);
    end

    step       = head_valid_i && (!out_valid_q || pop_i);
    head_pop_o = step && entry_done;

    busy_d = busy_q;
    pos_d  = pos_q;
    if (step) begin
      busy_d = !entry_done;
      pos_d  = next_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= POS_HDR0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= cur_byte;
      out_last_q <= (cur_pos == POS_TRL_FF2);
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

  `SSN_ASSERT_IMPLY(a_busy_has_head, clk_i, rst_ni, busy_q, head_valid_i)
  `SSN_ASSERT_IMPLY(a_busy_pos_range, clk_i, rst_ni, busy_q, pos_q <= POS_TRL_FF2)
  `SSN_ASSERT_IMPLY(a_last_is_trailer, clk_i, rst_ni, out_valid_q && out_last_q,
                    out_byte_q == MARKER_BYTE)

endmodule

[rtl/segment_stream_normalizer_unit.sv]
// The first result byte of an item passes the item queue and then the output register.
// Throughput: one input item per cycle while full is low, and one result byte per cycle while
// an entry is queued and the output is empty or popped; a header gives 4 bytes, the ending 4 or 10.
// The item queue between parser and sequencer holds QueueDepth entries.
// Reset is asynchronous and active low; it clears the parser state, the queue and the output.
module segment_stream_normalizer_unit #(
  parameter int unsigned QueueDepth = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import ssn_pkg::*;

  logic   accept;
  logic   q_push;
  entry_t q_entry;
  logic   q_full;
  logic   q_pop;
  entry_t q_head;
  logic   q_valid;

  assign full   = q_full;
  assign accept = push && !q_full;

  ssn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (q_push),
    .entry_o   (q_entry)
  );

  ssn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .valid_o (q_valid)
  );

  ssn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .head_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule
